// File: rtl/gf4_periodic_autocorrelation_check_macros.svh
// ----------------------------------------------------------------------------
// gf4 periodic autocorrelation check - assertion macros
// shared property forms, clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GF4_PERIODIC_AUTOCORRELATION_CHECK_MACROS_SVH
`define GF4_PERIODIC_AUTOCORRELATION_CHECK_MACROS_SVH

// same-cycle implication
`define GF4PAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GF4PAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/gf4pac_pkg.sv
// ----------------------------------------------------------------------------
// gf4pac_pkg
// constants, types and gf(4) helpers of the periodic autocorrelation check
// ----------------------------------------------------------------------------
package gf4pac_pkg;

	localparam int SEQ_LEN      = 35;
	localparam int ACTIVE_COUNT = 12;
	localparam int MAX_SHIFT    = 17;

	localparam int CNT_W   = $clog2(SEQ_LEN + 1);
	localparam int DIG_W   = (ACTIVE_COUNT > 1) ? $clog2(ACTIVE_COUNT) : 1;
	localparam int SHIFT_W = $clog2(MAX_SHIFT + 1);

	// gf(4) element, coded bit0 + w*bit1
	typedef logic [1:0] gf4_t;

	localparam gf4_t GF4_ZERO = 2'd0;
	localparam gf4_t GF4_ONE  = 2'd1;
	localparam gf4_t GF4_W    = 2'd2;
	localparam gf4_t GF4_W2   = 2'd3;

	// phase digit codes
	localparam logic [1:0] DIG_ONE = 2'd0;
	localparam logic [1:0] DIG_W2  = 2'd1;

	typedef gf4_t [SEQ_LEN-1:0]   gf4_vec_t;
	typedef gf4_t [MAX_SHIFT-1:0] corr_vec_t;

	typedef struct packed {
		logic [1:0] phase_0;
		logic [1:0] phase_1;
		logic [1:0] phase_2;
		logic [1:0] phase_3;
		logic [1:0] phase_4;
		logic [1:0] phase_5;
		logic [1:0] phase_6;
		logic [1:0] phase_7;
		logic [1:0] phase_8;
		logic [1:0] phase_9;
		logic [1:0] phase_10;
		logic [1:0] phase_11;
	} in_t;

	typedef struct packed {
		logic               all_zero;
		logic [SHIFT_W-1:0] first_failing_shift;
		gf4_t               failing_value;
		logic               mask_valid;
	} out_t;

	// per-stage control carried along the pipeline
	typedef struct packed {
		logic valid;
		logic mask_valid;
	} stage_ctl_t;

	function automatic gf4_t gf4_mul(input gf4_t a, input gf4_t b);
		gf4_t c;
		c[0] = (a[0] & b[0]) ^ (a[1] & b[1]);
		c[1] = (a[0] & b[1]) ^ (a[1] & b[0]) ^ (a[1] & b[1]);
		return c;
	endfunction

	// digit three falls through to w like digit two
	function automatic gf4_t digit_to_elem(input logic [1:0] d);
		gf4_t e;
		case (d)
			DIG_ONE: e = GF4_ONE;
			DIG_W2:  e = GF4_W2;
			default: e = GF4_W;
		endcase
		return e;
	endfunction

endpackage

// File: rtl/gf4pac_lane.sv
// ----------------------------------------------------------------------------
// gf4pac_lane
// one shift lane: xor over positions of x[q] * conj(y[q]), registered
// ----------------------------------------------------------------------------
module gf4pac_lane
	import gf4pac_pkg::*;
(
	input  logic     clk,
	input  gf4_vec_t x,
	input  gf4_vec_t y,
	output gf4_t     corr_s2
);

	gf4_t acc;

	always_comb begin
		acc = GF4_ZERO;
		for (int q = 0; q < SEQ_LEN; q++) begin
			// conj(v) = v^2
			acc = acc ^ gf4_mul(x[q], gf4_mul(y[q], y[q]));
		end
	end

	always_ff @(posedge clk) begin
		corr_s2 <= acc;
	end

endmodule

// File: rtl/gf4pac_merge.sv
// ----------------------------------------------------------------------------
// gf4pac_merge
// picks the lowest failing shift across all lanes and registers the result
// ----------------------------------------------------------------------------
module gf4pac_merge
	import gf4pac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl_s2,
	input  corr_vec_t  corr_s2,
	output logic       done,
	output out_t       result
);

	logic [SHIFT_W-1:0] first;
	gf4_t               fval;
	logic               done_q;
	out_t               result_q;

	// scan from the top so the lowest nonzero shift wins
	always_comb begin
		first = '0;
		fval  = GF4_ZERO;
		for (int i = MAX_SHIFT - 1; i >= 0; i--) begin
			if (corr_s2[i] != GF4_ZERO) begin
				first = SHIFT_W'(i + 1);
				fval  = corr_s2[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.all_zero            <= ctl_s2.mask_valid && (first == '0);
		result_q.first_failing_shift <= first;
		result_q.failing_value       <= fval;
		result_q.mask_valid          <= ctl_s2.mask_valid;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/gf4_periodic_autocorrelation_check.sv
// ----------------------------------------------------------------------------
// gf4_periodic_autocorrelation_check
// periodic autocorrelation test of a masked cyclic gf(4) sequence
// ----------------------------------------------------------------------------
// usage
//   config: write the 35-bit support mask on cfg_data with cfg_valid; cfg_ready
//     is always high, so no write is ever held off. write only while
//     no item is in flight. the position ranks are derived at write time.
//   input: an item (twelve phase digits) transfers at a clock edge with start
//     high and busy low. busy is held low, so a new item can enter every cycle.
//   output: done pulses for one cycle with the result fields on result; the
//     receiver has no way to stall, so every result must be taken as shown.
//   path: an accepted item passes the scatter register, lane register and
//     merge register in that order before it shows on result with done.
//   throughput: one item per clock; the 17 shift lanes run side by side,
//     each a full 35-position product and xor tree.
//   reset: arst_n clears the mask to zero (mask_valid reads 0) and drops all
//     pipeline valid bits, so nothing is reported for items caught in flight.
// ----------------------------------------------------------------------------
`include "gf4_periodic_autocorrelation_check_macros.svh"

module gf4_periodic_autocorrelation_check
	import gf4pac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SEQ_LEN-1:0] cfg_data,
	// item command channel
	input  logic               start,
	output logic               busy,
	input  in_t                phase,
	// result strobe
	output logic               done,
	output out_t               result
);

	// derived mask state
	logic [SEQ_LEN-1:0] active_q;
	logic [DIG_W-1:0]   rank_q [SEQ_LEN];
	logic               mask_valid_q;

	logic [CNT_W-1:0]   rank_next [SEQ_LEN];
	logic [SEQ_LEN-1:0] active_next;
	logic [CNT_W-1:0]   total_next;

	// digit unpack and scatter
	logic [1:0] phase_arr [ACTIVE_COUNT];
	gf4_vec_t   x_next;
	gf4_vec_t   x_s1;
	stage_ctl_t ctl_s1;
	stage_ctl_t ctl_s2;

	// lane wiring
	gf4_vec_t   rot [MAX_SHIFT];
	corr_vec_t  corr_s2;

	logic       accept;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign accept    = start && !busy;

	// rank of each position = number of set mask bits below it
	always_comb begin
		for (int q = 0; q < SEQ_LEN; q++) begin
			rank_next[q] = CNT_W'($countones(cfg_data &
				((SEQ_LEN'(1) << q) - SEQ_LEN'(1))));
			// only the lowest ACTIVE_COUNT set bits take digits
			active_next[q] = cfg_data[q] && (rank_next[q] < CNT_W'(ACTIVE_COUNT));
		end
		total_next = CNT_W'($countones(cfg_data));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			mask_valid_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			active_q     <= active_next;
			mask_valid_q <= (total_next == CNT_W'(ACTIVE_COUNT));
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			for (int q = 0; q < SEQ_LEN; q++) begin
				rank_q[q] <= rank_next[q][DIG_W-1:0];
			end
		end
	end

	// digits in position order
	assign phase_arr[0]  = phase.phase_0;
	assign phase_arr[1]  = phase.phase_1;
	assign phase_arr[2]  = phase.phase_2;
	assign phase_arr[3]  = phase.phase_3;
	assign phase_arr[4]  = phase.phase_4;
	assign phase_arr[5]  = phase.phase_5;
	assign phase_arr[6]  = phase.phase_6;
	assign phase_arr[7]  = phase.phase_7;
	assign phase_arr[8]  = phase.phase_8;
	assign phase_arr[9]  = phase.phase_9;
	assign phase_arr[10] = phase.phase_10;
	assign phase_arr[11] = phase.phase_11;

	// each active position picks its digit by rank; inactive ones are zero
	always_comb begin
		for (int q = 0; q < SEQ_LEN; q++) begin
			x_next[q] = active_q[q] ? digit_to_elem(phase_arr[rank_q[q]]) : GF4_ZERO;
		end
	end

	// stage 1: scattered sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.valid      <= accept;
			ctl_s1.mask_valid <= mask_valid_q;
			ctl_s2            <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= x_next;
		end
	end

	// stage 2: one lane per shift, fed the cyclically rotated sequence
	for (genvar s = 1; s <= MAX_SHIFT; s++) begin : g_lane
		for (genvar q = 0; q < SEQ_LEN; q++) begin : g_rot
			assign rot[s-1][q] = x_s1[(q + s) % SEQ_LEN];
		end

		gf4pac_lane u_lane (
			.clk     (clk),
			.x       (x_s1),
			.y       (rot[s-1]),
			.corr_s2 (corr_s2[s-1])
		);
	end

	// stage 3: first failing shift and result register
	gf4pac_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s2  (ctl_s2),
		.corr_s2 (corr_s2),
		.done    (done),
		.result  (result)
	);

	// every item leaving the lanes is reported next cycle
	`GF4PAC_ASSERT_NEXT(a_lane_to_done, ctl_s2.valid, done, "lane output lost before done")
	// a perfect report needs a valid mask and no failing shift
	`GF4PAC_ASSERT_NOW(a_perfect_consistent, done && result.all_zero,
		result.mask_valid && (result.first_failing_shift == '0), "all_zero inconsistent")
	// a reported failing shift always carries a nonzero value
	`GF4PAC_ASSERT_NOW(a_fail_value, done && (result.first_failing_shift != '0),
		result.failing_value != GF4_ZERO, "failing shift with zero value")

endmodule

// File: sim/gf4_periodic_autocorrelation_check_test.sv
// ----------------------------------------------------------------------------
// gf4_periodic_autocorrelation_check_test
// self-checking bench for the gf(4) periodic autocorrelation check: loads a
// series of support masks (empty, all ones, valid twelve-position masks and
// malformed ones), streams phase-digit items under random start gaps and
// checks every strobed result against an in-bench autocorrelation predictor
// ----------------------------------------------------------------------------
module gf4_periodic_autocorrelation_check_test
	import gf4pac_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// three register stages from accepting edge to the done strobe
	localparam int LATENCY     = 3;
	localparam int SETTLE      = LATENCY + 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PHASES = 30;
	localparam int PHASE_ITEMS = 60;

	// digit code to field element, code three aliases w
	localparam logic [7:0] DIGIT_LUT = {GF4_W, GF4_W, GF4_W2, GF4_ONE};

	typedef struct packed {
		in_t         digits;
		logic [3:0]  gap;
	} pending_item_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SEQ_LEN-1:0] cfg_data  = '0;
	logic               start     = 1'b0;
	logic               busy;
	in_t                phase     = '0;
	logic               done;
	out_t               result;

	pending_item_t      pending_items[$];
	out_t               expected_results[$];
	logic [SEQ_LEN-1:0] mask_shadow = '0;
	int unsigned        idle_cycles;
	int unsigned        items_sent;
	int unsigned        results_checked;
	int unsigned        invalid_seen;
	int unsigned        perfect_seen;
	int unsigned        masks_written;
	int unsigned        fail_count;
	int unsigned        cycle_count;
	out_t               want;

	gf4_periodic_autocorrelation_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.phase     (phase),
		.done      (done),
		.result    (result)
	);

	always #5 clk = ~clk;

	// a * conj(b) = a * b^2; nonzero codes 1,2,3 are w^0, w^1, w^2,
	// so the log of a nonzero element is its code minus one
	function automatic gf4_t conj_product(input gf4_t a, input gf4_t b);
		int unsigned expo;
		if (a == GF4_ZERO || b == GF4_ZERO)
			return GF4_ZERO;
		expo = ((a - 1) + 2 * (b - 1)) % 3;
		return gf4_t'(expo + 1);
	endfunction

	// expected result for one item under a given support mask
	function automatic out_t autocorr_predict(input logic [SEQ_LEN-1:0] mask,
	                                          input in_t digits);
		gf4_t        seq [SEQ_LEN];
		gf4_t        acc;
		logic [1:0]  dig;
		int unsigned taken;
		int unsigned count;
		out_t        r;
		taken = 0;
		count = 0;
		r = '0;
		// active positions take digits in position order, extras stay zero
		for (int q = 0; q < SEQ_LEN; q++) begin
			seq[q] = GF4_ZERO;
			if (mask[q]) begin
				count++;
				if (taken < ACTIVE_COUNT) begin
					// phase_0 sits in the top bits of the packed item
					dig = digits[(ACTIVE_COUNT - 1 - taken) * 2 +: 2];
					seq[q] = DIGIT_LUT[dig * 2 +: 2];
					taken++;
				end
			end
		end
		for (int s = 1; s <= MAX_SHIFT && r.first_failing_shift == 0; s++) begin
			acc = GF4_ZERO;
			for (int q = 0; q < SEQ_LEN; q++)
				acc ^= conj_product(seq[q], seq[(q + s) % SEQ_LEN]);
			if (acc != GF4_ZERO) begin
				r.first_failing_shift = SHIFT_W'(s);
				r.failing_value = acc;
			end
		end
		r.mask_valid = (count == ACTIVE_COUNT);
		r.all_zero = r.mask_valid && (r.first_failing_shift == 0);
		return r;
	endfunction

	// mostly legal digits, code three now and then
	function automatic in_t random_digits();
		in_t d;
		for (int k = 0; k < ACTIVE_COUNT; k++)
			d[k * 2 +: 2] = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		return d;
	endfunction

	function automatic logic [SEQ_LEN-1:0] mask_with_count(input int unsigned n);
		logic [SEQ_LEN-1:0] m;
		m = '0;
		while ($countones(m) < n)
			m[$urandom_range(0, SEQ_LEN - 1)] = 1'b1;
		return m;
	endfunction

	// ------------------------------------------------------------------------
	// driver: one item per transfer, optional start gap before each item
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start       <= 1'b0;
			phase       <= '0;
			idle_cycles <= 0;
		end else begin
			// transfer at this edge: the mask cannot change while items are in flight
			if (start && !busy) begin
				expected_results.insert(expected_results.size(),
				                        autocorr_predict(mask_shadow, phase));
				items_sent++;
			end
			// a stalled item stays on the port untouched
			if (!(start && busy)) begin
				if (pending_items.size() == 0) begin
					start <= 1'b0;
				end else if (idle_cycles < pending_items[0].gap) begin
					start       <= 1'b0;
					idle_cycles <= idle_cycles + 1;
				end else begin
					start       <= 1'b1;
					phase       <= pending_items.pop_front().digits;
					idle_cycles <= 0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: each done strobe is a transfer that cannot be held off
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no item outstanding");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (!result.mask_valid)
					invalid_seen++;
				if (result.all_zero)
					perfect_seen++;
				if (result.all_zero !== want.all_zero) begin
					$error("all_zero: expected %0d, got %0d", want.all_zero, result.all_zero);
					fail_count++;
				end
				if (result.first_failing_shift !== want.first_failing_shift) begin
					$error("first_failing_shift: expected %0d, got %0d",
					       want.first_failing_shift, result.first_failing_shift);
					fail_count++;
				end
				if (result.failing_value !== want.failing_value) begin
					$error("failing_value: expected %0d, got %0d",
					       want.failing_value, result.failing_value);
					fail_count++;
				end
				if (result.mask_valid !== want.mask_valid) begin
					$error("mask_valid: expected %0d, got %0d",
					       want.mask_valid, result.mask_valid);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("gf4_periodic_autocorrelation_check_test NOT OK");
			$finish;
		end
	end

	// queue one item, back to back in burst phases
	task automatic queue_item(input in_t digits, input bit burst);
		pending_item_t p;
		p.digits = digits;
		p.gap = burst ? 4'd0 : 4'($urandom_range(0, 9));
		pending_items.insert(pending_items.size(), p);
	endtask

	// wait until nothing is queued, driven or outstanding, then let the pipe drain
	task automatic settle();
		@(negedge clk);
		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mask write transfer, only with the block idle
	task automatic load_mask(input logic [SEQ_LEN-1:0] value);
		settle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		mask_shadow = value;
		masks_written++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [SEQ_LEN-1:0] m;
		bit                 burst;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// mask still at its reset value: nothing active, invalid
		queue_item(in_t'({ACTIVE_COUNT{2'd0}}), 1'b0);
		queue_item(in_t'({ACTIVE_COUNT{2'd3}}), 1'b0);

		// twelve consecutive positions, every digit code, uniform and mixed
		load_mask(SEQ_LEN'(12'hFFF));
		queue_item(in_t'({ACTIVE_COUNT{2'd0}}), 1'b1);
		queue_item(in_t'({ACTIVE_COUNT{2'd1}}), 1'b1);
		queue_item(in_t'({ACTIVE_COUNT{2'd2}}), 1'b1);
		queue_item(in_t'({ACTIVE_COUNT{2'd3}}), 1'b1);
		queue_item(in_t'(24'h1B1B1B), 1'b1);

		// top twelve positions, the shifted partner wraps around
		load_mask({12'hFFF, 23'd0});
		queue_item(random_digits(), 1'b0);
		queue_item(random_digits(), 1'b0);

		// every position set: only the lowest twelve take digits
		load_mask('1);
		queue_item(in_t'({ACTIVE_COUNT{2'd1}}), 1'b0);
		queue_item(random_digits(), 1'b0);

		// one too few and one too many active positions
		load_mask(mask_with_count(ACTIVE_COUNT - 1));
		queue_item(random_digits(), 1'b0);
		load_mask(mask_with_count(ACTIVE_COUNT + 1));
		queue_item(random_digits(), 1'b0);

		// lone top position: no pair, no correlation
		load_mask(SEQ_LEN'(1) << (SEQ_LEN - 1));
		queue_item(random_digits(), 1'b0);

		// pair seventeen apart: only the last shift can fail
		load_mask((SEQ_LEN'(1) << MAX_SHIFT) | SEQ_LEN'(1));
		queue_item(random_digits(), 1'b0);

		// every third position, twelve in all
		for (int q = 0; q < SEQ_LEN; q += 3)
			m[q] = 1'b1;
		for (int q = 0; q < SEQ_LEN; q++)
			if (q % 3 != 0)
				m[q] = 1'b0;
		load_mask(m);
		queue_item(random_digits(), 1'b0);
		queue_item(random_digits(), 1'b0);

		// random phases: mostly valid twelve-position masks, some malformed
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0:       m = mask_with_count($urandom_range(0, SEQ_LEN));
				1:       m = SEQ_LEN'({$urandom, $urandom});
				default: m = mask_with_count(ACTIVE_COUNT);
			endcase
			burst = ($urandom_range(0, 3) == 0);
			load_mask(m);
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_item(random_digits(), burst);
		end

		// explicit write of the empty mask
		load_mask('0);
		queue_item(random_digits(), 1'b0);
		queue_item(random_digits(), 1'b1);

		settle();

		$display("%0d items sent, %0d results checked under %0d mask writes",
		         items_sent, results_checked, masks_written);
		$display("%0d results with an invalid mask, %0d with all shifts clear",
		         invalid_seen, perfect_seen);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("gf4_periodic_autocorrelation_check_test OK");
		end else begin
			$display("gf4_periodic_autocorrelation_check_test NOT OK");
		end
		$finish;
	end

endmodule
